/* design/ptc_pkg.sv */
// Shared types and constants for the page table translator with clock replacement.
package ptc_pkg;

  localparam int PA_W       = 32;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [STATUS_W-1:0] STAT_LOADED    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_HIT       = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_REPLACED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_SEGFAULT  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DISKFAULT = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NOVICTIM  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PA_BITS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_ENABLE = 2'd3;

  typedef struct packed {
    logic [4:0] page_shift;
    logic [6:0] entry_count;
    logic [5:0] pa_bits;
    logic       clock_enable;
  } cfg_t;

endpackage

/* design/ptc_cfg_regs.sv */
// Configuration register file for the page table translator.
module ptc_cfg_regs
  import ptc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PAGE_SHIFT:   cfg_d.page_shift   = cfg_data_i[4:0];
        CFG_ENTRY_COUNT:  cfg_d.entry_count  = cfg_data_i[6:0];
        CFG_PA_BITS:      cfg_d.pa_bits      = cfg_data_i[5:0];
        CFG_CLOCK_ENABLE: cfg_d.clock_enable = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_shift   <= 5'd12;
      cfg_q.entry_count  <= 7'd64;
      cfg_q.pa_bits      <= 6'd32;
      cfg_q.clock_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/ptc_table_ram.sv */
// Page table storage: one write port and one registered read port.
module ptc_table_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 19
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

endmodule

/* design/ptc_walk_ctrl.sv */
// Sequencer: lookup, fault decode and clock hand walk over the page table.
module ptc_walk_ctrl
  import ptc_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAME_BITS  = 16,
  parameter int ADDR_BITS   = 32,
  localparam int IDX_W      = $clog2(TABLE_DEPTH),
  localparam int WORD_W     = FRAME_BITS + 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [ADDR_BITS-1:0]  virtual_address_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic                  entry_valid_i,
  input  logic                  entry_backed_i,
  input  logic [FRAME_BITS-1:0] entry_frame_i,
  input  logic                  entry_used_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [STATUS_W-1:0]   res_status_o,
  output logic [PA_W-1:0]       res_pa_o,
  output logic [IDX_W-1:0]      res_victim_o,
  output logic                  rd_en_o,
  output logic [IDX_W-1:0]      rd_addr_o,
  input  logic [WORD_W-1:0]     rd_data_i,
  output logic                  wr_en_o,
  output logic [IDX_W-1:0]      wr_addr_o,
  output logic [WORD_W-1:0]     wr_data_o
);

  localparam int CNT_W = ($clog2(TABLE_DEPTH + 1) > 7) ? $clog2(TABLE_DEPTH + 1) : 7;
  localparam int CMP_W = (ADDR_BITS > CNT_W) ? ADDR_BITS : CNT_W;
  localparam int VA_W  = (ADDR_BITS > PA_W) ? ADDR_BITS : PA_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_PAGE   = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_FIX    = 3'd5;

  function automatic logic [PA_W-1:0] make_pa(input logic [FRAME_BITS-1:0] fr,
                                              input logic [ADDR_BITS-1:0]  va,
                                              input cfg_t                  c);
    logic [VA_W-1:0] va_w;
    logic [PA_W-1:0] off_mask;
    logic [PA_W:0]   wide;
    logic [PA_W-1:0] base;
    logic [5:0]      pw;
    va_w     = VA_W'(va);
    off_mask = (PA_W'(1) << c.page_shift) - PA_W'(1);
    pw       = (c.pa_bits > 6'(PA_W)) ? 6'(PA_W) : c.pa_bits;
    wide     = ((PA_W + 1)'(1) << pw) - (PA_W + 1)'(1);
    base     = (PA_W'(fr) << c.page_shift) | (va_w[PA_W-1:0] & off_mask);
    return base & wide[PA_W-1:0];
  endfunction

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      hand_q, hand_d;
  logic [ADDR_BITS-1:0]  va_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  ev_q, eb_q, eu_q;
  logic [FRAME_BITS-1:0] ef_q;
  logic [IDX_W-1:0]      page_q, page_d;
  logic [IDX_W-1:0]      h_q, h_d;
  logic [CNT_W-1:0]      vis_q, vis_d;
  logic                  seen_q, seen_d;
  logic [IDX_W-1:0]      vic_idx_q, vic_idx_d;
  logic [FRAME_BITS-1:0] vic_frame_q, vic_frame_d;

  logic                  accept;
  logic [CNT_W-1:0]      cnt_raw, n;
  logic [ADDR_BITS-1:0]  vpn;
  logic                  e_valid, e_backed, e_used;
  logic [FRAME_BITS-1:0] e_frame;
  logic [CNT_W-1:0]      h_inc;
  logic [IDX_W-1:0]      h_next;

  assign e_valid  = rd_data_i[WORD_W-1];
  assign e_backed = rd_data_i[WORD_W-2];
  assign e_used   = rd_data_i[WORD_W-3];
  assign e_frame  = rd_data_i[FRAME_BITS-1:0];

  assign cnt_raw = CNT_W'(cfg_i.entry_count);
  assign n = (cnt_raw == '0) ? CNT_W'(1) :
             (cnt_raw > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cnt_raw;

  assign vpn    = va_q >> cfg_i.page_shift;
  assign h_inc  = CNT_W'(h_q) + CNT_W'(1);
  assign h_next = (h_inc >= n) ? '0 : h_inc[IDX_W-1:0];

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    hand_d       = hand_q;
    page_d       = page_q;
    h_d          = h_q;
    vis_d        = vis_q;
    seen_d       = seen_q;
    vic_idx_d    = vic_idx_q;
    vic_frame_d  = vic_frame_q;
    res_valid_o  = 1'b0;
    res_status_o = STAT_LOADED;
    res_pa_o     = '0;
    res_victim_o = '0;
    rd_en_o      = 1'b0;
    rd_addr_o    = page_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = page_q;
    wr_data_o    = rd_data_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = opcode_i ? S_DECODE : S_LOAD;
        end
      end
      S_LOAD: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          wr_en_o   = ((IDX_W + 1)'(idx_q) < (IDX_W + 1)'(TABLE_DEPTH));
          wr_addr_o = idx_q;
          wr_data_o = {ev_q, eb_q, eu_q, ef_q};
          state_d   = S_IDLE;
        end
      end
      S_DECODE: begin
        if (CMP_W'(vpn) >= CMP_W'(n)) begin
          res_valid_o  = 1'b1;
          res_status_o = STAT_NOVICTIM;
          if (res_ready_i) begin
            state_d = S_IDLE;
          end
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = vpn[IDX_W-1:0];
          page_d    = vpn[IDX_W-1:0];
          state_d   = S_PAGE;
        end
      end
      S_PAGE: begin
        if (e_valid) begin
          res_valid_o  = 1'b1;
          res_status_o = STAT_HIT;
          res_pa_o     = make_pa(e_frame, va_q, cfg_i);
          if (res_ready_i) begin
            wr_en_o   = 1'b1;
            wr_data_o = {1'b1, e_backed, 1'b1, e_frame};
            state_d   = S_IDLE;
          end
        end else if (!e_backed || !cfg_i.clock_enable) begin
          res_valid_o  = 1'b1;
          res_status_o = e_backed ? STAT_DISKFAULT : STAT_SEGFAULT;
          if (res_ready_i) begin
            state_d = S_IDLE;
          end
        end else begin
          h_d       = (CNT_W'(hand_q) < n) ? hand_q : '0;
          rd_en_o   = 1'b1;
          rd_addr_o = h_d;
          vis_d     = '0;
          seen_d    = 1'b0;
          state_d   = S_WALK;
        end
      end
      S_WALK: begin
        wr_addr_o = h_q;
        if (e_valid) begin
          seen_d = 1'b1;
          wr_en_o = 1'b1;
          wr_data_o = {e_valid, e_backed, 1'b0, e_frame};
          if (e_used) begin
            rd_en_o   = 1'b1;
            rd_addr_o = h_next;
            h_d       = h_next;
          end else begin
            wr_data_o   = {1'b0, e_backed, 1'b0, e_frame};
            vic_idx_d   = h_q;
            vic_frame_d = e_frame;
            hand_d      = h_next;
            state_d     = S_FIX;
          end
        end else if (!seen_q && (vis_q + CNT_W'(1) == n)) begin
          res_valid_o  = 1'b1;
          res_status_o = STAT_NOVICTIM;
          if (res_ready_i) begin
            state_d = S_IDLE;
          end
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = h_next;
          h_d       = h_next;
          vis_d     = vis_q + CNT_W'(1);
        end
      end
      S_FIX: begin
        res_valid_o  = 1'b1;
        res_status_o = STAT_REPLACED;
        res_pa_o     = make_pa(vic_frame_q, va_q, cfg_i);
        res_victim_o = vic_idx_q;
        if (res_ready_i) begin
          wr_en_o   = 1'b1;
          wr_data_o = {1'b1, 1'b1, 1'b1, vic_frame_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hand_q  <= '0;
    end else begin
      state_q <= state_d;
      hand_q  <= hand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      va_q  <= virtual_address_i;
      idx_q <= entry_index_i;
      ev_q  <= entry_valid_i;
      eb_q  <= entry_backed_i;
      ef_q  <= entry_frame_i;
      eu_q  <= entry_used_i;
    end
    page_q      <= page_d;
    h_q         <= h_d;
    vis_q       <= vis_d;
    seen_q      <= seen_d;
    vic_idx_q   <= vic_idx_d;
    vic_frame_q <= vic_frame_d;
  end

endmodule

/* design/page_translate_clock_replace.sv */
// Top level: page table translation with clock replacement.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | opcode, virtual_address, entry_*
//  out     | output    | out_valid_o/out_stall_i | status, physical_address, victim_index
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each step of the clock walk reads one entry through the single table read port; the
// clock hand visits at most about twice the entry count in one walk.
// Reset clears the sequencer, the clock hand and the output valid flag and loads the
// configuration defaults; table contents stay undefined until loaded. The result
// register lets a new item in while a result waits under out_stall_i; a finished item
// holds in the sequencer until it drains.
module page_translate_clock_replace
  import ptc_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAME_BITS  = 16,
  parameter int ADDR_BITS   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic [ADDR_BITS-1:0]             virtual_address_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   entry_index_i,
  input  logic                             entry_valid_i,
  input  logic                             entry_backed_i,
  input  logic [FRAME_BITS-1:0]            entry_frame_i,
  input  logic                             entry_used_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [STATUS_W-1:0]              status_o,
  output logic [PA_W-1:0]                  physical_address_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   victim_index_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [CFG_DATA_W-1:0]            cfg_data_i
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int WORD_W = FRAME_BITS + 3;

  cfg_t              cfg;
  logic              res_valid, res_ready;
  logic [STATUS_W-1:0] res_status;
  logic [PA_W-1:0]   res_pa;
  logic [IDX_W-1:0]  res_victim;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [WORD_W-1:0] rd_data, wr_data;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q;
  logic [PA_W-1:0]     pa_q;
  logic [IDX_W-1:0]    victim_q;

  ptc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ptc_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ptc_walk_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAME_BITS  (FRAME_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .virtual_address_i (virtual_address_i),
    .entry_index_i     (entry_index_i),
    .entry_valid_i     (entry_valid_i),
    .entry_backed_i    (entry_backed_i),
    .entry_frame_i     (entry_frame_i),
    .entry_used_i      (entry_used_i),
    .res_valid_o       (res_valid),
    .res_ready_i       (res_ready),
    .res_status_o      (res_status),
    .res_pa_o          (res_pa),
    .res_victim_o      (res_victim),
    .rd_en_o           (rd_en),
    .rd_addr_o         (rd_addr),
    .rd_data_i         (rd_data),
    .wr_en_o           (wr_en),
    .wr_addr_o         (wr_addr),
    .wr_data_o         (wr_data)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      status_q <= res_status;
      pa_q     <= res_pa;
      victim_q <= res_victim;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign physical_address_o = pa_q;
  assign victim_index_o     = victim_q;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the page table translator with clock replacement.
`timescale 1ns / 100ps

module tb_top
  import ptc_pkg::*;
;

  localparam int DEPTH      = 64;
  localparam int IDX_W      = 6;
  localparam int FRM_W      = 16;
  localparam int VA_W       = 32;
  localparam int CYCLE_CAP  = 1000000;
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  typedef struct packed {
    logic             op;
    logic [VA_W-1:0]  va;
    logic [IDX_W-1:0] idx;
    logic             v;
    logic             b;
    logic [FRM_W-1:0] frame;
    logic             u;
  } pte_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     pa;
    logic [IDX_W-1:0]    victim;
  } xlate_res_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  in_valid_i          = 1'b0;
  logic                  in_stall_o;
  logic                  opcode_i            = 1'b0;
  logic [VA_W-1:0]       virtual_address_i   = '0;
  logic [IDX_W-1:0]      entry_index_i       = '0;
  logic                  entry_valid_i       = 1'b0;
  logic                  entry_backed_i      = 1'b0;
  logic [FRM_W-1:0]      entry_frame_i       = '0;
  logic                  entry_used_i        = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i         = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [PA_W-1:0]       physical_address_o;
  logic [IDX_W-1:0]      victim_index_o;
  logic                  cfg_valid_i         = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i         = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i          = '0;

  page_translate_clock_replace #(
    .TABLE_DEPTH(DEPTH),
    .FRAME_BITS (FRM_W),
    .ADDR_BITS  (VA_W)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .virtual_address_i (virtual_address_i),
    .entry_index_i     (entry_index_i),
    .entry_valid_i     (entry_valid_i),
    .entry_backed_i    (entry_backed_i),
    .entry_frame_i     (entry_frame_i),
    .entry_used_i      (entry_used_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .physical_address_o(physical_address_o),
    .victim_index_o    (victim_index_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // page table shadow and register copy
  logic             tbl_valid  [DEPTH];
  logic             tbl_backed [DEPTH];
  logic [FRM_W-1:0] tbl_frame  [DEPTH];
  logic             tbl_use    [DEPTH];
  logic [IDX_W-1:0] clk_hand   = '0;
  cfg_t model_cfg = '{page_shift: 5'd12, entry_count: 7'd64, pa_bits: 6'd32,
                      clock_enable: 1'b1};

  pte_req_t   pend_q[$];
  xlate_res_t xlate_exp_q[$];
  xlate_res_t got;
  xlate_res_t want;

  int unsigned issued_cnt = 0;
  int unsigned in_acc_cnt = 0;
  int unsigned in_seen    = 0;
  int unsigned res_cnt    = 0;
  int unsigned errors     = 0;
  int unsigned in_gap     = 0;
  int unsigned st_left    = 0;
  int unsigned hold_left  = 0;
  int unsigned next_hold  = 100;
  int unsigned cycles     = 0;
  int unsigned gap        = 0;
  bit          calm_in    = 1'b0;
  bit          calm_out   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [PA_W-1:0] phys_addr(int unsigned pg, logic [VA_W-1:0] va);
    logic [63:0] off_mask;
    logic [63:0] pa64;
    int unsigned pw;
    off_mask = (64'd1 << model_cfg.page_shift) - 64'd1;
    pa64 = ({48'd0, tbl_frame[pg]} << model_cfg.page_shift) | ({32'd0, va} & off_mask);
    pw = (model_cfg.pa_bits > 6'd32) ? 32 : model_cfg.pa_bits;
    pa64 = pa64 & ((64'd1 << pw) - 64'd1);
    return pa64[PA_W-1:0];
  endfunction

  function automatic xlate_res_t translate_step(pte_req_t it);
    xlate_res_t  r;
    int unsigned n;
    int unsigned h;
    int unsigned pg;
    logic [63:0] vpn;
    logic        any;
    logic        found;
    r = '0;
    r.status = STAT_LOADED;
    if (it.op == OP_LOAD) begin
      tbl_valid[it.idx]  = it.v;
      tbl_backed[it.idx] = it.b;
      tbl_frame[it.idx]  = it.frame;
      tbl_use[it.idx]    = it.u;
    end else begin
      n = model_cfg.entry_count;
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      vpn = {32'd0, it.va} >> model_cfg.page_shift;
      if (vpn >= n) begin
        r.status = STAT_NOVICTIM;
      end else begin
        pg = vpn[31:0];
        if (tbl_valid[pg]) begin
          tbl_use[pg] = 1'b1;
          r.pa = phys_addr(pg, it.va);
          r.status = STAT_HIT;
        end else if (!tbl_backed[pg]) begin
          r.status = STAT_SEGFAULT;
        end else if (!model_cfg.clock_enable) begin
          r.status = STAT_DISKFAULT;
        end else begin
          any = 1'b0;
          for (int i = 0; i < n; i++) if (tbl_valid[i]) any = 1'b1;
          if (!any) begin
            r.status = STAT_NOVICTIM;
          end else begin
            h = (clk_hand < n) ? clk_hand : 0;
            found = 1'b0;
            while (!found) begin
              if (tbl_valid[h]) begin
                if (tbl_use[h]) begin
                  tbl_use[h] = 1'b0;
                end else begin
                  tbl_valid[h]  = 1'b0;
                  tbl_frame[pg] = tbl_frame[h];
                  tbl_valid[pg] = 1'b1;
                  r.victim = h[IDX_W-1:0];
                  found = 1'b1;
                end
              end
              h = (h + 1 >= n) ? 0 : h + 1;
            end
            clk_hand = h[IDX_W-1:0];
            tbl_use[pg] = 1'b1;
            r.pa = phys_addr(pg, it.va);
            r.status = STAT_REPLACED;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // drive the input channel
  always @(negedge clk_i) begin
    if (!in_valid_i || in_acc_cnt != in_seen) begin
      in_seen = in_acc_cnt;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() != 0) begin
        pte_req_t it;
        it = pend_q.pop_front();
        opcode_i          <= it.op;
        virtual_address_i <= it.va;
        entry_index_i     <= it.idx;
        entry_valid_i     <= it.v;
        entry_backed_i    <= it.b;
        entry_frame_i     <= it.frame;
        entry_used_i      <= it.u;
        in_valid_i        <= 1'b1;
        if ($urandom_range(49) == 0) calm_in = !calm_in;
        in_gap = calm_in ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off while items keep coming
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (res_cnt >= next_hold && pend_q.size() > 10) begin
      hold_left <= 150;
      next_hold <= next_hold + 230;
    end
  end

  // drive the output stall
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
    end else if (st_left > 0) begin
      st_left--;
      out_stall_i <= 1'b1;
    end else begin
      if ($urandom_range(39) == 0) calm_out = !calm_out;
      gap = calm_out ? 0 : pick_gap();
      if (gap > 0) begin
        st_left = gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // predict on accepted items, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      xlate_exp_q.push_back(translate_step('{op: opcode_i, va: virtual_address_i,
                                             idx: entry_index_i, v: entry_valid_i,
                                             b: entry_backed_i, frame: entry_frame_i,
                                             u: entry_used_i}));
      in_acc_cnt++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      res_cnt++;
      got = '{status: status_o, pa: physical_address_o, victim: victim_index_o};
      if (xlate_exp_q.size() == 0) begin
        $display("%0t: unexpected result status %0d pa %h victim %0d",
                 $realtime, got.status, got.pa, got.victim);
        errors++;
      end else begin
        want = xlate_exp_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected status %0d pa %h victim %0d, got status %0d pa %h victim %0d",
                   $realtime, want.status, want.pa, want.victim,
                   got.status, got.pa, got.victim);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_CAP) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  function automatic pte_req_t load_req(int unsigned idx, bit v, bit b, int unsigned frame,
                                        bit u);
    return '{op: OP_LOAD, va: VA_W'($urandom), idx: IDX_W'(idx), v: v, b: b,
             frame: FRM_W'(frame), u: u};
  endfunction

  function automatic pte_req_t xlate_req(logic [VA_W-1:0] va);
    return '{op: OP_XLATE, va: va, idx: IDX_W'($urandom), v: 1'($urandom),
             b: 1'($urandom), frame: FRM_W'($urandom), u: 1'($urandom)};
  endfunction

  task automatic offer(pte_req_t it);
    pend_q.push_back(it);
    issued_cnt++;
  endtask

  task automatic settle();
    while (res_cnt != issued_cnt) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PAGE_SHIFT:   model_cfg.page_shift   = data[4:0];
      CFG_ENTRY_COUNT:  model_cfg.entry_count  = data[6:0];
      CFG_PA_BITS:      model_cfg.pa_bits      = data[5:0];
      CFG_CLOCK_ENABLE: model_cfg.clock_enable = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly in-range translates and loads, some raw addresses
  task automatic push_random(int unsigned cnt);
    int unsigned n;
    int unsigned r;
    int unsigned pg;
    logic [63:0] va64;
    logic [63:0] off_mask;
    n = model_cfg.entry_count;
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    off_mask = (64'd1 << model_cfg.page_shift) - 64'd1;
    repeat (cnt) begin
      r = $urandom_range(99);
      if (r < 40) begin
        pg = (r < 34) ? $urandom_range(n - 1) : $urandom_range(DEPTH - 1);
        offer(load_req(pg, $urandom_range(99) < 55, $urandom_range(1), $urandom,
                       $urandom_range(1)));
      end else if (r < 90) begin
        pg = $urandom_range(n - 1);
        va64 = ({32'd0, pg} << model_cfg.page_shift) | ({32'd0, $urandom} & off_mask);
        offer(xlate_req(va64[VA_W-1:0]));
      end else begin
        offer(xlate_req($urandom));
      end
    end
  endtask

  initial begin
    cfg_t c;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DEPTH; i++) begin
      offer(load_req(i, $urandom_range(1), $urandom_range(1), $urandom, $urandom_range(1)));
    end

    offer(load_req(5, 1, 1, 16'hFFFF, 0));
    offer(xlate_req(32'h0000_5FFF));
    offer(load_req(0, 1, 0, 16'h0000, 1));
    offer(xlate_req(32'h0000_0000));
    offer(xlate_req(32'hFFFF_FFFF));
    offer(xlate_req(32'h0004_0000));
    offer(xlate_req(32'h0003_F123));
    offer(load_req(7, 0, 0, 16'h1234, 0));
    offer(xlate_req(32'h0000_7ABC));
    offer(load_req(9, 0, 1, 16'h0000, 1));
    offer(xlate_req(32'h0000_9001));
    offer(xlate_req(32'h0000_9FFE));
    push_random(85);

    for (int p = 0; p < 7; p++) begin
      settle();
      case (p)
        0: c = '{page_shift: 5'd0,  entry_count: 7'd8,   pa_bits: 6'd32, clock_enable: 1'b1};
        1: c = '{page_shift: 5'd24, entry_count: 7'd1,   pa_bits: 6'd1,  clock_enable: 1'b1};
        2: c = '{page_shift: 5'd31, entry_count: 7'd127, pa_bits: 6'd63, clock_enable: 1'b0};
        3: c = '{page_shift: 5'd4,  entry_count: 7'd0,   pa_bits: 6'd0,  clock_enable: 1'b1};
        4: c = '{page_shift: 5'd12, entry_count: 7'd64,  pa_bits: 6'd20, clock_enable: 1'b1};
        default: begin
          c.page_shift   = $urandom_range(31);
          c.entry_count  = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(64, 1);
          c.pa_bits      = $urandom_range(63);
          c.clock_enable = $urandom_range(1);
        end
      endcase
      cfg_write(CFG_PAGE_SHIFT,   CFG_DATA_W'(c.page_shift));
      cfg_write(CFG_ENTRY_COUNT,  CFG_DATA_W'(c.entry_count));
      cfg_write(CFG_PA_BITS,      CFG_DATA_W'(c.pa_bits));
      cfg_write(CFG_CLOCK_ENABLE, CFG_DATA_W'(c.clock_enable));
      case (p)
        0: begin
          offer(load_req(3, 1, 1, 16'h00A5, 0));
          offer(load_req(2, 0, 1, 16'h0000, 0));
          offer(xlate_req(32'h0000_0002));
        end
        1: begin
          offer(load_req(0, 0, 1, 16'h0042, 1));
          offer(xlate_req(32'h0000_0000));
          offer(xlate_req(32'h00FF_FFFF));
          offer(xlate_req(32'h0100_0000));
        end
        2: begin
          offer(load_req(1, 0, 1, 16'h0001, 0));
          offer(xlate_req(32'h8000_0000));
          offer(load_req(0, 1, 1, 16'hFFFF, 0));
          offer(xlate_req(32'h7FFF_FFFF));
        end
        3: begin
          offer(load_req(0, 1, 0, 16'hFFFF, 0));
          offer(xlate_req(32'h0000_000F));
        end
        default: ;
      endcase
      push_random(47);
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (xlate_exp_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, xlate_exp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
